>>> rtl/core/fla_pkg.sv
// ---------------------------------------------------------------------------
// fla_pkg - shared types and constants for the free list index allocator
// Word layouts, action and status codes, controller states and the command
// bundle that the controller hands to the datapath.
// ---------------------------------------------------------------------------
package fla_pkg;

   // Field widths of the request and response words
   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = INDEX_W + 1;

   // Number of slots in the pool; one for every value of an index
   localparam int POOL_DEPTH = 1 << INDEX_W;

   // Stream word widths, padded up to whole bytes
   localparam int REQ_BITS    = ACTION_W + INDEX_W;
   localparam int RSP_BITS    = INDEX_W + STATUS_W + COUNT_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FETCH       = 2'd0,
      ACT_RELEASE     = 2'd1,
      ACT_RELEASE_ALL = 2'd2,
      ACT_NONE        = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_REPLY = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       start;
      action_type action;
   } cmd_type;

endpackage

>>> rtl/core/fla_ctrl.sv
// ---------------------------------------------------------------------------
// fla_ctrl - allocator controller
// Two-state machine: take one request word, then hold the response word until
// the sink takes it. Issues the start command and decoded action.
// ---------------------------------------------------------------------------
module fla_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fla_pkg::ACTION_W-1:0]  req_action,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output fla_pkg::cmd_type              cmd
);
   import fla_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_REPLY: rsp_tvalid = 1'b1;
         default: req_tready = 1'b0;
      endcase
      cmd.start  = req_tvalid && req_tready;
      cmd.action = action_type'(req_action);
   end

endmodule

>>> rtl/core/fla_datapath.sv
// ---------------------------------------------------------------------------
// fla_datapath - free stack, allocation pointer and response registers
// The stack is a memory with a registered read; per-entry valid bits stand in
// for the identity fill, so an entry never written since reset or release-all
// reads as its own index.
// ---------------------------------------------------------------------------
module fla_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  fla_pkg::cmd_type              cmd,
   input  logic [fla_pkg::INDEX_W-1:0]   release_index,
   output logic [fla_pkg::INDEX_W-1:0]   granted_index,
   output logic [fla_pkg::STATUS_W-1:0]  status,
   output logic [fla_pkg::COUNT_W-1:0]   in_use_count
);
   import fla_pkg::*;

   logic [INDEX_W-1:0]    stack_mem [POOL_DEPTH];
   logic [POOL_DEPTH-1:0] valid_ff;

   logic [COUNT_W-1:0]    ptr_ff, ptr_in;
   logic                  grant_ok_ff, grant_ok_in;
   status_type            status_ff, status_in;

   logic [INDEX_W-1:0]    rd_data_ff;
   logic [INDEX_W-1:0]    rd_addr_ff;
   logic                  rd_valid_ff;

   logic [COUNT_W-1:0]    ptr_dec;
   logic [INDEX_W-1:0]    rd_addr;
   logic [INDEX_W-1:0]    wr_addr;
   logic                  wr_en;
   logic                  clear_all;
   logic                  full;
   logic                  empty;

   assign ptr_dec = ptr_ff - COUNT_W'(1);
   assign rd_addr = ptr_ff[INDEX_W-1:0];
   assign wr_addr = ptr_dec[INDEX_W-1:0];
   assign full    = (ptr_ff == COUNT_W'(POOL_DEPTH));
   assign empty   = (ptr_ff == '0);

   // Decode the action into pointer moves and stack writes
   always_comb begin
      ptr_in      = ptr_ff;
      grant_ok_in = grant_ok_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      clear_all   = 1'b0;
      if (cmd.start) begin
         grant_ok_in = 1'b0;
         status_in   = ST_OK;
         case (cmd.action)
            ACT_FETCH: begin
               if (full) begin
                  status_in = ST_EMPTY;
               end else begin
                  grant_ok_in = 1'b1;
                  ptr_in      = ptr_ff + COUNT_W'(1);
               end
            end
            ACT_RELEASE: begin
               if (empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  ptr_in = ptr_dec;
                  wr_en  = 1'b1;
               end
            end
            ACT_RELEASE_ALL: begin
               clear_all = 1'b1;
               ptr_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Pointer and response status
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         grant_ok_ff <= 1'b0;
         status_ff   <= ST_OK;
      end else begin
         ptr_ff      <= ptr_in;
         grant_ok_ff <= grant_ok_in;
         status_ff   <= status_in;
      end
   end

   // Drop all written entries back to identity on reset and release-all
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Stack memory: one write port, one registered read at the pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= release_index;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_data_ff  <= stack_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
   end

   // Result fields
   assign granted_index = grant_ok_ff ? (rd_valid_ff ? rd_data_ff : rd_addr_ff) : '0;
   assign status        = status_ff;
   assign in_use_count  = ptr_ff;

endmodule

>>> rtl/core/free_list_index_allocator.sv
// ---------------------------------------------------------------------------
// free_list_index_allocator - stack based free slot index allocator
// Hands out and takes back slot indices kept on a free stack; one response
// word for every request word.
//
//   channel  direction  tdata fields (low bit first)
//   req_     in         action[1:0], release_index[9:2], zero pad to 16
//   rsp_     out        granted_index[7:0], status[9:8], in_use_count[18:10],
//                       zero pad to 24
//
// Each request is accepted while the controller is idle and its response shows
// in the cycle after; the response fields come from registers, the stack
// memory read among them. A new request is taken only once the response has
// been accepted, so requests are not overlapped. Release-all needs no pass
// over the memory, as the per-entry valid bits are all cleared together. Reset
// is synchronous and needs no clearing pass.
// ---------------------------------------------------------------------------
module free_list_index_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action[1:0], release_index[9:2], zero [15:10]
   input  logic [fla_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // granted_index[7:0], status[9:8], in_use_count[18:10], zero [23:19]
   output logic [fla_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import fla_pkg::*;

   cmd_type             cmd;
   logic [INDEX_W-1:0]  granted_index;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  in_use_count;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tdata[ACTION_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fla_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .release_index (req_tdata[ACTION_W +: INDEX_W]),
      .granted_index (granted_index),
      .status        (status),
      .in_use_count  (in_use_count)
   );

   // Pack the response word
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, in_use_count, status, granted_index};

endmodule

>>> rtl/core/fla_checker.sv
// ---------------------------------------------------------------------------
// fla_checker - port level checks for the free list index allocator
// Watches the stream ports only and reports rule breaks.
// ---------------------------------------------------------------------------
module fla_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [fla_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fla_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import fla_pkg::*;

   logic [INDEX_W-1:0]  chk_granted;
   logic [STATUS_W-1:0] chk_status;
   logic [COUNT_W-1:0]  chk_count;

   assign chk_granted = rsp_tdata[INDEX_W-1:0];
   assign chk_status  = rsp_tdata[INDEX_W +: STATUS_W];
   assign chk_count   = rsp_tdata[INDEX_W + STATUS_W +: COUNT_W];

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // Every accepted request word shows a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after accepted request");

   // Empty pool reported only with every slot in use, and no index granted
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && chk_status == ST_EMPTY |->
         chk_count == COUNT_W'(POOL_DEPTH) && chk_granted == '0)
      else $error("empty status with slots still free");

   // Release underflow reported only with nothing allocated
   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && chk_status == ST_UNDERFLOW |-> chk_count == '0)
      else $error("underflow status with slots in use");

   // Count never exceeds the pool size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> chk_count <= COUNT_W'(POOL_DEPTH))
      else $error("in-use count beyond pool size");

endmodule

bind free_list_index_allocator fla_checker u_fla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
